// ----- sv/fat_lnp_pkg.sv -----
// Shared types, constants and helper functions for the long-name entry parser.
// No dependencies; every other file of the block refers to this package.
package fat_lnp_pkg;

  // Entry layout and rule constants
  localparam logic [7:0] AttrLfn      = 8'h0F;
  localparam logic [7:0] ByteDeleted  = 8'hE5;
  localparam logic [7:0] ByteSpace    = 8'h20;
  localparam logic [7:0] OrdMask      = 8'hBF;
  localparam int unsigned OrdFirstBit = 6;
  localparam int unsigned AttrVolBit  = 3;
  localparam int unsigned AttrDirBit  = 4;
  localparam logic [7:0] MaxSlots     = 8'd20;
  localparam logic [3:0] CharsPerSlot = 4'd13;

  // Result queue depth
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    EV_SKIP    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_SLOT    = 3'd2,
    EV_LONG    = 3'd3,
    EV_ABANDON = 3'd4,
    EV_END     = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_SLOTS = 3'b010,
    PH_SHORT = 3'b100
  } phase_e;

  // One result item
  typedef struct packed {
    event_e      ev;
    logic [7:0]  off;
    logic [4:0]  cnt;
    logic [15:0] start;
    logic        dir;
    logic        last;
  } res_t;

  // Up to two results produced by one entry
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } step_t;

  // Pre-decoded entry held in the input register
  typedef struct packed {
    logic            kind;
    logic [7:0]      b0;
    logic [7:0]      attr;
    logic [7:0]      chk;
    logic            blank;
    logic [7:0]      psum;
    logic [4:0][7:0] tail;
  } entry_t;

  // One rotate-right-then-add step of the short-name checksum
  function automatic logic [7:0] rot_add(input logic [7:0] s, input logic [7:0] b);
    return {s[0], s[7:1]} + b;
  endfunction

  // Character offset of a slot, kept to 8 bits
  function automatic logic [7:0] slot_offset(input logic [4:0] n);
    logic [8:0] p;
    p = 9'(n) * 9'(CharsPerSlot);
    return p[7:0];
  endfunction

endpackage

// ----- sv/fat_lnp_ingress.sv -----
// Input register of the parser: takes one entry item, pre-decodes it.
// Depends on fat_lnp_pkg (entry_t, rot_add, constants).
module fat_lnp_ingress (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tvalid_i,
  output logic                 tready_o,
  input  logic [255:0]         tdata_i,
  input  logic                 tuser_i,
  input  logic                 take_i,
  output logic                 vld_o,
  output fat_lnp_pkg::entry_t  entry_o
);

  logic                vld_q, vld_d;
  fat_lnp_pkg::entry_t entry_q, entry_d;
  logic [10:0][7:0]    nb;
  logic                stop;
  logic                blank;
  logic [7:0]          psum;

  // Short-name bytes 0 to 10
  always_comb begin
    for (int i = 0; i < 11; i++) begin
      nb[i] = tdata_i[8*i +: 8];
    end
  end

  // Blank-name check: only spaces before the first zero in each part
  always_comb begin
    blank = 1'b1;
    stop  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        if (nb[i] == 8'h00) begin
          stop = 1'b1;
        end else if (nb[i] != fat_lnp_pkg::ByteSpace) begin
          blank = 1'b0;
        end
      end
    end
    stop = 1'b0;
    for (int i = 8; i < 11; i++) begin
      if (!stop) begin
        if (nb[i] == 8'h00) begin
          stop = 1'b1;
        end else if (nb[i] != fat_lnp_pkg::ByteSpace) begin
          blank = 1'b0;
        end
      end
    end
  end

  // First half of the checksum, bytes 0 to 5
  always_comb begin
    psum = nb[0];
    for (int i = 1; i < 6; i++) begin
      psum = fat_lnp_pkg::rot_add(psum, nb[i]);
    end
  end

  assign tready_o = !vld_q || take_i;

  always_comb begin
    entry_d       = entry_q;
    vld_d         = vld_q;
    if (take_i) begin
      vld_d = 1'b0;
    end
    if (tvalid_i && tready_o) begin
      vld_d         = 1'b1;
      entry_d.kind  = tuser_i;
      entry_d.b0    = nb[0];
      entry_d.attr  = tdata_i[95:88];
      entry_d.chk   = tdata_i[111:104];
      entry_d.blank = blank;
      entry_d.psum  = psum;
      for (int i = 0; i < 5; i++) begin
        entry_d.tail[i] = nb[6 + i];
      end
    end
  end

  // Hold valid under reset; payload needs none
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign vld_o   = vld_q;
  assign entry_o = entry_q;

endmodule

// ----- sv/fat_lnp_core.sv -----
// Run tracker of the parser: slot-run state and the results of one entry.
// Depends on fat_lnp_pkg (entry_t, step_t, phase_e, event_e, helpers).
module fat_lnp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 lnames_en_i,
  input  logic                 proc_i,
  input  fat_lnp_pkg::entry_t  entry_i,
  output fat_lnp_pkg::step_t   step_o
);

  fat_lnp_pkg::phase_e phase_q, phase_d;
  logic [4:0]          exp_q, exp_d;
  logic [4:0]          total_q, total_d;
  logic [7:0]          alias_q, alias_d;
  logic [15:0]         rec_q, rec_d;
  logic [15:0]         idx_q, idx_d;

  logic [7:0]          sum;
  logic [7:0]          cnt8;
  logic [4:0]          cnt_m1;
  logic                f_slot;
  logic                active;
  logic                brk;
  fat_lnp_pkg::res_t   fres;
  fat_lnp_pkg::res_t   ares;
  fat_lnp_pkg::res_t   r0, r1;
  logic                two;

  // Finish the checksum over bytes 6 to 10
  always_comb begin
    sum = entry_i.psum;
    for (int i = 0; i < 5; i++) begin
      sum = fat_lnp_pkg::rot_add(sum, entry_i.tail[i]);
    end
  end

  assign cnt8   = entry_i.b0 & fat_lnp_pkg::OrdMask;
  assign cnt_m1 = cnt8[4:0] - 5'd1;

  // Examine the entry as the start of a new record
  always_comb begin
    fres       = '0;
    fres.ev    = fat_lnp_pkg::EV_SKIP;
    fres.start = idx_q;
    f_slot     = 1'b0;
    if (!lnames_en_i) begin
      if (!(entry_i.attr[fat_lnp_pkg::AttrVolBit] || entry_i.b0 == 8'h00 ||
            entry_i.b0 == fat_lnp_pkg::ByteDeleted) && !entry_i.blank) begin
        fres.ev  = fat_lnp_pkg::EV_SHORT;
        fres.dir = entry_i.attr[fat_lnp_pkg::AttrDirBit];
      end
    end else if (entry_i.b0 == fat_lnp_pkg::ByteDeleted) begin
      fres.ev = fat_lnp_pkg::EV_SKIP;
    end else if (entry_i.attr != fat_lnp_pkg::AttrLfn) begin
      if (!(entry_i.attr[fat_lnp_pkg::AttrVolBit] || entry_i.b0 == 8'h00) &&
          !entry_i.blank) begin
        fres.ev  = fat_lnp_pkg::EV_SHORT;
        fres.dir = entry_i.attr[fat_lnp_pkg::AttrDirBit];
      end
    end else if (entry_i.b0[fat_lnp_pkg::OrdFirstBit] && cnt8 != 8'h00 &&
                 cnt8 <= fat_lnp_pkg::MaxSlots) begin
      f_slot   = 1'b1;
      fres.ev  = fat_lnp_pkg::EV_SLOT;
      fres.off = fat_lnp_pkg::slot_offset(cnt_m1);
    end
  end

  assign active = (phase_q == fat_lnp_pkg::PH_SLOTS) || (phase_q == fat_lnp_pkg::PH_SHORT);

  // Rule break inside an open run
  always_comb begin
    brk = 1'b0;
    if (!lnames_en_i) begin
      brk = 1'b1;
    end else if (phase_q == fat_lnp_pkg::PH_SLOTS) begin
      brk = (entry_i.attr != fat_lnp_pkg::AttrLfn) || (cnt8 != {3'b000, exp_q}) ||
            (entry_i.chk != alias_q);
    end else begin
      brk = (entry_i.b0 == fat_lnp_pkg::ByteDeleted) ||
            (entry_i.attr == fat_lnp_pkg::AttrLfn) || (entry_i.b0 == 8'h00) ||
            entry_i.attr[fat_lnp_pkg::AttrVolBit] || (sum != alias_q);
    end
  end

  always_comb begin
    ares       = '0;
    ares.ev    = fat_lnp_pkg::EV_ABANDON;
    ares.start = rec_q;
  end

  // Results and next state for the entry at the input register
  always_comb begin
    phase_d = phase_q;
    exp_d   = exp_q;
    total_d = total_q;
    alias_d = alias_q;
    rec_d   = rec_q;
    idx_d   = (idx_q == 16'hFFFF) ? idx_q : idx_q + 16'd1;
    r0      = fres;
    r1      = fres;
    two     = 1'b0;
    if (entry_i.kind) begin
      r1       = '0;
      r1.ev    = fat_lnp_pkg::EV_END;
      r1.start = idx_q;
      r0       = active ? ares : r1;
      two      = active;
      phase_d  = fat_lnp_pkg::PH_IDLE;
      idx_d    = '0;
    end else if (!active || brk) begin
      if (active) begin
        r0  = ares;
        two = 1'b1;
      end
      phase_d = fat_lnp_pkg::PH_IDLE;
      if (f_slot) begin
        rec_d   = idx_q;
        alias_d = entry_i.chk;
        total_d = cnt8[4:0];
        exp_d   = cnt_m1;
        phase_d = (cnt_m1 == 5'd0) ? fat_lnp_pkg::PH_SHORT : fat_lnp_pkg::PH_SLOTS;
      end
    end else if (phase_q == fat_lnp_pkg::PH_SLOTS) begin
      exp_d    = exp_q - 5'd1;
      phase_d  = (exp_d == 5'd0) ? fat_lnp_pkg::PH_SHORT : fat_lnp_pkg::PH_SLOTS;
      r0       = '0;
      r0.ev    = fat_lnp_pkg::EV_SLOT;
      r0.off   = fat_lnp_pkg::slot_offset(exp_d);
      r0.start = idx_q;
    end else begin
      phase_d  = fat_lnp_pkg::PH_IDLE;
      r0       = '0;
      r0.ev    = fat_lnp_pkg::EV_LONG;
      r0.cnt   = total_q;
      r0.start = rec_q;
      r0.dir   = entry_i.attr[fat_lnp_pkg::AttrDirBit];
    end
    r0.last = !two;
    r1.last = 1'b1;
  end

  // Advance run state once per processed entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fat_lnp_pkg::PH_IDLE;
      exp_q   <= '0;
      total_q <= '0;
      alias_q <= '0;
      rec_q   <= '0;
      idx_q   <= '0;
    end else if (proc_i) begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      total_q <= total_d;
      alias_q <= alias_d;
      rec_q   <= rec_d;
      idx_q   <= idx_d;
    end
  end

  assign step_o.r0  = r0;
  assign step_o.r1  = r1;
  assign step_o.two = two;

endmodule

// ----- sv/fat_lnp_outq.sv -----
// Result queue of the parser: takes one or two results a cycle, drains one.
// Depends on fat_lnp_pkg (res_t, step_t, queue sizes).
module fat_lnp_outq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  fat_lnp_pkg::step_t                step_i,
  input  logic                              pop_i,
  output logic                              vld_o,
  output fat_lnp_pkg::res_t                 head_o,
  output logic [fat_lnp_pkg::QCntW-1:0]     count_o
);

  fat_lnp_pkg::res_t                  mem_q [fat_lnp_pkg::QDepth];
  logic [fat_lnp_pkg::QPtrW-1:0]      wr_q, rd_q;
  logic [fat_lnp_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic [fat_lnp_pkg::QPtrW-1:0]      wr_n1;
  logic                               pop;
  logic [fat_lnp_pkg::QCntW-1:0]      n_push;

  assign pop    = pop_i && (cnt_q != '0);
  assign wr_n1  = wr_q + 1'b1;
  assign n_push = push_i ? (step_i.two ? fat_lnp_pkg::QCntW'(2) : fat_lnp_pkg::QCntW'(1))
                         : '0;
  assign cnt_d  = cnt_q + n_push - fat_lnp_pkg::QCntW'(pop);

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= step_i.r0;
      if (step_i.two) begin
        mem_q[wr_n1] <= step_i.r1;
      end
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + n_push[fat_lnp_pkg::QPtrW-1:0];
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign vld_o   = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ----- sv/fat_long_name_entry_parser_unit.sv -----
// Top level of the VFAT long-name directory entry parser.
// Depends on fat_lnp_pkg, fat_lnp_ingress, fat_lnp_core and fat_lnp_outq.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata: 32 entry bytes; tuser: kind
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata: result fields; tlast: is_last
//   cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i: long_names_enabled
//
// One entry item per cycle while the queue has room: it is stored in the
// input register, where the run tracker and checksum finish it, and its
// results enter a 4-deep queue; an item with two results puts the abandon first.
// Input is held while the queue has fewer than two free places.
// Reset empties both stages and the queue and enables long-name parsing.
module fat_long_name_entry_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // entry_word0, entry_word1, entry_word2, entry_word3
  input  logic         s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // event_res, name_offset, slot_count, start_index,
                                      // is_directory, zero fill
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_data_i
);

  logic                               lnames_en_q;
  logic                               in_vld;
  fat_lnp_pkg::entry_t                entry;
  logic                               proc;
  fat_lnp_pkg::step_t                 step;
  fat_lnp_pkg::res_t                  head;
  logic [fat_lnp_pkg::QCntW-1:0]      q_cnt;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lnames_en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lnames_en_q <= cfg_data_i;
    end
  end

  // Process the held item when two queue places are free
  assign proc = in_vld && (q_cnt <= fat_lnp_pkg::QCntW'(fat_lnp_pkg::QDepth - 2));

  fat_lnp_ingress u_ingress (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .tready_o (s_axis_tready),
    .tdata_i  (s_axis_tdata),
    .tuser_i  (s_axis_tuser),
    .take_i   (proc),
    .vld_o    (in_vld),
    .entry_o  (entry)
  );

  fat_lnp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lnames_en_i (lnames_en_q),
    .proc_i      (proc),
    .entry_i     (entry),
    .step_o      (step)
  );

  fat_lnp_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (proc),
    .step_i  (step),
    .pop_i   (m_axis_tready),
    .vld_o   (m_axis_tvalid),
    .head_o  (head),
    .count_o (q_cnt)
  );

  assign m_axis_tdata = {7'b0000000, head.dir, head.start, head.cnt, head.off, head.ev};
  assign m_axis_tlast = head.last;

`ifndef ASSERT_OFF
  // Queue never takes an item without room for two results
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> (q_cnt <= fat_lnp_pkg::QCntW'(fat_lnp_pkg::QDepth - 2)))
    else $error("item processed without queue room");

  // A two-result item always leads with an abandon
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && step.two) |-> (step.r0.ev == fat_lnp_pkg::EV_ABANDON))
    else $error("paired results without leading abandon");

  // Fill count grows by two after a paired push with no drain
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && step.two && !(m_axis_tvalid && m_axis_tready)) |=>
      (q_cnt == $past(q_cnt) + fat_lnp_pkg::QCntW'(2)))
    else $error("queue count did not track a paired push");
`endif

endmodule
